/* rtl/core/sxg_pkg.sv */
// Shared constants, types and tables of the spectral extraction gate.
`default_nettype none
package sxg_pkg;

  localparam int FRAME_SIZE = 1024;
  localparam int LOOKAHEAD  = 6;
  localparam int SLOTS      = LOOKAHEAD + 1;
  localparam int NUM_BINS   = FRAME_SIZE / 2 + 1;
  localparam int LAST_BIN   = NUM_BINS - 1;

  localparam int AMP_W   = 16;
  localparam int FREQ_W  = 24;
  localparam int BIN_W   = 10;
  localparam int F_W     = 3;
  localparam int LIM_W   = 23;
  localparam int MODE_W  = 2;
  localparam int SUM_W   = 27;
  localparam int NUM_W   = AMP_W + LIM_W;
  localparam int RECIP_W = 33;
  localparam int PROD_W  = SUM_W + RECIP_W;
  localparam int HIST_W  = AMP_W + FREQ_W;

  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 32;
  localparam int CFG_ADDR_W  = 1;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  // Register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_MODE  = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_LIMIT = 1'd1;

  // Mode codes
  localparam logic [MODE_W-1:0] MODE_PASS   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_NOISY  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_STABLE = 2'd2;

  localparam logic [LIM_W-1:0] LIMIT_RESET = 23'd160;

  // One queued item: amplitudes per frame back, deviation sums per frame back
  typedef struct packed {
    logic [SLOTS-1:0][AMP_W-1:0] amps;
    logic [SLOTS-1:0][SUM_W-1:0] sums;
    logic [BIN_W-1:0]            bin;
    logic [F_W-1:0]              f_start;
    logic                        is_final;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } push_t;

  // ceil(2^32 / f), exact floor division for sums below 2^27
  function automatic logic [RECIP_W-1:0] recip(input logic [F_W-1:0] f);
    logic [RECIP_W-1:0] r;
    case (f)
      3'd1:    r = 33'd4294967296;
      3'd2:    r = 33'd2147483648;
      3'd3:    r = 33'd1431655766;
      3'd4:    r = 33'd1073741824;
      3'd5:    r = 33'd858993460;
      3'd6:    r = 33'd715827883;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

/* rtl/core/sxg_front.sv */
// Front end: takes items, keeps bin history, forms deviation sums per frame.
`default_nettype none
module sxg_front (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  input  wire logic [sxg_pkg::IN_TDATA_W-1:0]    in_tdata,
  input  wire logic                              in_tlast,
  input  wire logic                              room,
  output logic [1:0]                             occ,
  output sxg_pkg::push_t                         push
);
  import sxg_pkg::*;

  // History rows: one slot per held frame
  logic [SLOTS-1:0][HIST_W-1:0] mem [NUM_BINS];

  logic [F_W-1:0] held_r, ws_r;
  logic           acc;
  logic [AMP_W-1:0]  in_amp;
  logic [FREQ_W-1:0] in_freq;
  logic [BIN_W-1:0]  in_bin;
  logic           bin_ok, has_res;

  // stage 1
  logic                         v1_r;
  logic [SLOTS-1:0][HIST_W-1:0] row_r;
  logic [AMP_W-1:0]             amp1_r;
  logic [FREQ_W-1:0]            frq1_r;
  logic [BIN_W-1:0]             bin1_r;
  logic [F_W-1:0]               ws1_r, fs1_r;
  logic                         fin1_r;

  // stage 2
  logic                                v2_r;
  logic [SLOTS-1:0][AMP_W-1:0]         amps2_r;
  logic [SLOTS-1:0][FREQ_W-1:0]        dif2_r;
  logic [BIN_W-1:0]                    bin2_r;
  logic [F_W-1:0]                      fs2_r;
  logic                                fin2_r;

  logic [SLOTS-1:0][AMP_W-1:0]  amps1;
  logic [SLOTS-1:0][FREQ_W-1:0] frq1;
  logic [SLOTS-1:0][FREQ_W-1:0] dif1;
  logic [SLOTS-1:0][SUM_W-1:0]  sums2;

  assign in_amp  = in_tdata[AMP_W-1:0];
  assign in_freq = in_tdata[AMP_W +: FREQ_W];
  assign in_bin  = in_tdata[AMP_W+FREQ_W +: BIN_W];
  assign acc     = in_tvalid && room;
  assign bin_ok  = in_bin <= BIN_W'(LAST_BIN);
  assign has_res = in_tlast || (held_r == F_W'(LOOKAHEAD));
  assign occ     = 2'(v1_r) + 2'(v2_r);

  // History write and row read, same port cycle
  always_ff @(posedge clk) begin
    if (acc && bin_ok) begin
      mem[in_bin][ws_r] <= {in_amp, in_freq};
    end
    row_r <= mem[in_bin];
  end

  // Frame position tracking
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
      ws_r   <= '0;
    end else if (acc && in_bin == BIN_W'(LAST_BIN)) begin
      if (in_tlast) begin
        held_r <= '0;
        ws_r   <= '0;
      end else begin
        ws_r <= (ws_r == F_W'(SLOTS - 1)) ? '0 : ws_r + 1'b1;
        if (held_r != F_W'(LOOKAHEAD)) held_r <= held_r + 1'b1;
      end
    end
  end

  // Stage 1 registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= acc && bin_ok && has_res;
    end
    amp1_r <= in_amp;
    frq1_r <= in_freq;
    bin1_r <= in_bin;
    ws1_r  <= ws_r;
    fs1_r  <= in_tlast ? held_r : F_W'(LOOKAHEAD);
    fin1_r <= in_tlast;
  end

  // Reorder the row by frames back; own slot comes from the item itself
  always_comb begin
    logic [F_W:0]      sl;
    logic [FREQ_W:0]   dd;
    for (int k = 0; k < SLOTS; k++) begin
      sl = (F_W+1)'(ws1_r) + (F_W+1)'(SLOTS - k);
      if (sl >= (F_W+1)'(SLOTS)) sl = sl - (F_W+1)'(SLOTS);
      if (k == 0) begin
        amps1[k] = amp1_r;
        frq1[k]  = frq1_r;
      end else begin
        amps1[k] = row_r[sl[F_W-1:0]][HIST_W-1 -: AMP_W];
        frq1[k]  = row_r[sl[F_W-1:0]][FREQ_W-1:0];
      end
    end
    dif1[0] = '0;
    for (int k = 1; k < SLOTS; k++) begin
      dd = {frq1[k][FREQ_W-1], frq1[k]} - {frq1[k-1][FREQ_W-1], frq1[k-1]};
      if (dd[FREQ_W]) dd = -dd;
      dif1[k] = dd[FREQ_W-1:0];
    end
  end

  // Stage 2 registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
    amps2_r <= amps1;
    dif2_r  <= dif1;
    bin2_r  <= bin1_r;
    fs2_r   <= fs1_r;
    fin2_r  <= fin1_r;
  end

  // Running sums of deviation over frames back
  always_comb begin
    sums2[0] = '0;
    for (int k = 1; k < SLOTS; k++) begin
      sums2[k] = sums2[k-1] + SUM_W'(dif2_r[k]);
    end
  end

  assign push.valid          = v2_r;
  assign push.entry.amps     = amps2_r;
  assign push.entry.sums     = sums2;
  assign push.entry.bin      = bin2_r;
  assign push.entry.f_start  = fs2_r;
  assign push.entry.is_final = fin2_r;

endmodule
`default_nettype wire

/* rtl/core/sxg_fifo.sv */
// Short queue between the front end and the result engine.
`default_nettype none
module sxg_fifo (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire sxg_pkg::push_t            push,
  input  wire logic                      pop,
  output sxg_pkg::entry_t                head,
  output logic                           empty,
  output logic [sxg_pkg::QCNT_W-1:0]     count
);
  import sxg_pkg::*;

  entry_t            q_r [QDEPTH];
  logic [QPTR_W-1:0] wp_r, rp_r;
  logic [QCNT_W-1:0] cnt_r;
  logic              do_pop;

  assign empty  = (cnt_r == '0);
  assign count  = cnt_r;
  assign head   = q_r[rp_r];
  assign do_pop = pop && !empty;

  // Storage
  always_ff @(posedge clk) begin
    if (push.valid) q_r[wp_r] <= push.entry;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push.valid) wp_r <= wp_r + 1'b1;
      if (do_pop)     rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + QCNT_W'(push.valid) - QCNT_W'(do_pop);
    end
  end

endmodule
`default_nettype wire

/* rtl/core/sxg_back.sv */
// Result engine: walks frames of each item, averages, gates and divides.
`default_nettype none
module sxg_back (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [sxg_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  wire logic [sxg_pkg::LIM_W-1:0]         cfg_wdata,
  input  wire sxg_pkg::entry_t                   head,
  input  wire logic                              empty,
  output logic                                   pop,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [sxg_pkg::OUT_TDATA_W-1:0]        out_tdata,
  output logic                                   out_tlast
);
  import sxg_pkg::*;

  typedef enum logic [1:0] {OP_ZERO, OP_PASS, OP_SCALE} op_t;

  typedef struct packed {
    logic [AMP_W-1:0] amp;
    op_t              op;
    logic [NUM_W-1:0] rem;
    logic [AMP_W-1:0] q;
    logic [BIN_W-1:0] bin;
    logic [F_W-1:0]   f;
    logic             last;
  } dst_t;

  logic [MODE_W-1:0] mode_r;
  logic [LIM_W-1:0]  lim_r;

  logic           adv, issue;
  logic           mid_r;
  logic [F_W-1:0] f_r, f_iss;
  logic           last_iss;

  // issue stage
  logic             v0_r, l0_r;
  logic [AMP_W-1:0] a0_r;
  logic [SUM_W-1:0] s0_r;
  logic [F_W-1:0]   f0_r;
  logic [BIN_W-1:0] b0_r;
  // average stage
  logic             v1_r, l1_r;
  logic [AMP_W-1:0] a1_r;
  logic [SUM_W-1:0] d1_r;
  logic [F_W-1:0]   f1_r;
  logic [BIN_W-1:0] b1_r;
  logic [PROD_W-1:0] prod0;
  // gate stage
  logic             v2_r, l2_r;
  logic [AMP_W-1:0] a2_r;
  op_t              op2_r, op1;
  logic [LIM_W-1:0] x2_r, x1;
  logic [F_W-1:0]   f2_r;
  logic [BIN_W-1:0] b2_r;
  // product stage
  logic             v3_r;
  dst_t             p3_r;
  // divider
  logic [AMP_W-1:0] dv_r;
  dst_t             dr_r [AMP_W];
  dst_t             dn   [AMP_W];

  logic             ov_r, ol_r;
  logic [OUT_TDATA_W-1:0] od_r;
  logic [AMP_W-1:0] res_amp;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_PASS;
      lim_r  <= LIMIT_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_MODE:  mode_r <= cfg_wdata[MODE_W-1:0];
        REG_LIMIT: lim_r  <= cfg_wdata;
        default:   ;
      endcase
    end
  end

  assign adv      = !ov_r || out_tready;
  assign issue    = adv && !empty;
  assign f_iss    = mid_r ? f_r : head.f_start;
  assign last_iss = !head.is_final || (f_iss == '0);
  assign pop      = issue && last_iss;

  // Frame walker over the head item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mid_r <= 1'b0;
    end else if (issue) begin
      mid_r <= !last_iss;
    end
    if (issue) f_r <= f_iss - 1'b1;
  end

  // Issue stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (adv) begin
      v0_r <= !empty;
    end
    if (adv) begin
      a0_r <= head.amps[f_iss];
      s0_r <= head.sums[f_iss];
      f0_r <= f_iss;
      b0_r <= head.bin;
      l0_r <= last_iss;
    end
  end

  // Average by reciprocal multiply
  assign prod0 = PROD_W'(s0_r) * PROD_W'(recip(f0_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= v0_r;
    end
    if (adv) begin
      a1_r <= a0_r;
      d1_r <= prod0[32 +: SUM_W];
      f1_r <= f0_r;
      b1_r <= b0_r;
      l1_r <= l0_r;
    end
  end

  // Gate decision
  always_comb begin
    logic [SUM_W-1:0] lim_x;
    lim_x = SUM_W'(lim_r);
    op1   = OP_PASS;
    x1    = '0;
    case (mode_r)
      MODE_NOISY: begin
        if (d1_r <= lim_x) begin
          op1 = OP_ZERO;
        end else if (d1_r < (lim_x << 1)) begin
          op1 = OP_SCALE;
          x1  = LIM_W'(d1_r - lim_x);
        end
      end
      MODE_STABLE: begin
        if (d1_r < lim_x) begin
          op1 = OP_SCALE;
          x1  = LIM_W'(lim_x - d1_r);
        end else begin
          op1 = OP_ZERO;
        end
      end
      default: op1 = OP_PASS;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv) begin
      v2_r <= v1_r;
    end
    if (adv) begin
      a2_r  <= a1_r;
      op2_r <= op1;
      x2_r  <= x1;
      f2_r  <= f1_r;
      b2_r  <= b1_r;
      l2_r  <= l1_r;
    end
  end

  // Scale numerator
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (adv) begin
      v3_r <= v2_r;
    end
    if (adv) begin
      p3_r.amp  <= a2_r;
      p3_r.op   <= op2_r;
      p3_r.rem  <= NUM_W'(a2_r) * NUM_W'(x2_r);
      p3_r.q    <= '0;
      p3_r.bin  <= b2_r;
      p3_r.f    <= f2_r;
      p3_r.last <= l2_r;
    end
  end

  // Restoring divide by the limit, one quotient bit per stage
  always_comb begin
    dst_t             src;
    logic [NUM_W-1:0] trial;
    for (int j = 0; j < AMP_W; j++) begin
      src   = (j == 0) ? p3_r : dr_r[(j == 0) ? 0 : j - 1];
      trial = NUM_W'(lim_r) << (AMP_W - 1 - j);
      dn[j] = src;
      if (src.rem >= trial) begin
        dn[j].rem             = src.rem - trial;
        dn[j].q[AMP_W-1-j]    = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r <= '0;
    end else if (adv) begin
      dv_r <= {dv_r[AMP_W-2:0], v3_r};
    end
    if (adv) begin
      for (int j = 0; j < AMP_W; j++) dr_r[j] <= dn[j];
    end
  end

  // Output register
  always_comb begin
    case (dr_r[AMP_W-1].op)
      OP_PASS:  res_amp = dr_r[AMP_W-1].amp;
      OP_SCALE: res_amp = dr_r[AMP_W-1].q;
      default:  res_amp = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (adv) begin
      ov_r <= dv_r[AMP_W-1];
    end
    if (adv) begin
      od_r <= OUT_TDATA_W'({dr_r[AMP_W-1].f, dr_r[AMP_W-1].bin, res_amp});
      ol_r <= dr_r[AMP_W-1].last;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
  assign out_tlast  = ol_r;

endmodule
`default_nettype wire

/* rtl/core/spectral_extract_gate.sv */
// Top level of the spectral extraction gate.
//
//  channel | direction | handshake          | contents
//  in_     | slave     | tvalid/tready      | tdata: amp_in, freq_in, bin_index; tlast: last_frame
//  out_    | master    | tvalid/tready      | tdata: amp_out, bin_out, frames_back; tlast: last
//  cfg_    | write     | cfg_we             | cfg_addr 0 mode, 1 freq_limit; cfg_wdata
//
// One item per cycle enters while the queue has room; a steady frame gives at most
// one result a cycle. An item of the final frame gives held frames + 1 results, one
// per cycle unless the output stalls, set by the frame walker in the result engine.
// An accepted item's result reaches out_tvalid through the history read, the sums,
// the queue, the issue, average, gate and product stages, a 16-step divider and the output register.
// Reset is synchronous; history contents are not cleared.
// A stalled output holds the whole result engine; the front end stops taking
// items when the 4-entry queue cannot hold what is in flight.
`default_nettype none
module spectral_extract_gate (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [sxg_pkg::IN_TDATA_W-1:0]    in_tdata,  // amp_in[15:0], freq_in[39:16], bin_index[49:40]
  input  wire logic                              in_tlast,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [sxg_pkg::OUT_TDATA_W-1:0]        out_tdata, // amp_out[15:0], bin_out[25:16], frames_back[28:26]
  output logic                                   out_tlast,
  input  wire logic                              cfg_we,
  input  wire logic [sxg_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  wire logic [sxg_pkg::LIM_W-1:0]         cfg_wdata
);
  import sxg_pkg::*;

  push_t             push;
  entry_t            head;
  logic              empty, pop, room;
  logic [1:0]        occ;
  logic [QCNT_W-1:0] q_cnt;
  logic [QCNT_W:0]   fill;

  // Credit check: queue plus items still in the front end
  assign fill      = (QCNT_W+1)'(q_cnt) + (QCNT_W+1)'(occ);
  assign room      = fill < (QCNT_W+1)'(QDEPTH);
  assign in_tready = room;

  sxg_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .room      (room),
    .occ       (occ),
    .push      (push)
  );

  sxg_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (pop),
    .head  (head),
    .empty (empty),
    .count (q_cnt)
  );

  sxg_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .head       (head),
    .empty      (empty),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
`default_nettype wire

/* rtl/core/sxg_checker.sv */
// Port-level checks of the spectral extraction gate, bound to the top level.
`default_nettype none
module sxg_port_checks (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              out_tvalid,
  input wire logic                              out_tready,
  input wire logic [sxg_pkg::OUT_TDATA_W-1:0]   out_tdata,
  input wire logic                              out_tlast
);
  import sxg_pkg::*;

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped under stall");

  // Nothing offered right after reset
  a_rst_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result after reset");

  // Frames back never exceeds the lookahead
  a_fb_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[28:26] != 3'd7)
    else $error("frames_back out of range");

  // The newest frame's result always closes a final flush
  a_zero_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[28:26] == 3'd0 |-> out_tlast)
    else $error("newest frame result not marked last");

endmodule

bind spectral_extract_gate sxg_port_checks u_sxg_checker (.*);
`default_nettype wire
